FILE: hw/rtl/vro_pkg.sv
package vro_pkg;

    localparam int TrigIterationsDefault = 16;
    localparam int TrigIterationsMax = 24;

    // Opcodes of an input word.
    localparam logic [1:0] OP_COMMAND = 2'd0;
    localparam logic [1:0] OP_TICK    = 2'd1;
    localparam logic [1:0] OP_SET     = 2'd2;

    // Register indexes.
    localparam logic [2:0] REG_TICK_PERIOD   = 3'd0;
    localparam logic [2:0] REG_TIMEOUT_TICKS = 3'd1;
    localparam logic [2:0] REG_LINEAR_ACCEL  = 3'd2;
    localparam logic [2:0] REG_ANGULAR_ACCEL = 3'd3;
    localparam logic [2:0] REG_LINEAR_BRAKE  = 3'd4;
    localparam logic [2:0] REG_ANGULAR_BRAKE = 3'd5;

    // CORDIC start vector, 0.60725293 in Q2.30, and 2^32/(2pi).
    localparam logic [31:0] CORDIC_START = 32'd652032874;
    localparam logic [30:0] RAD_TO_TURN  = 31'd683565276;

    typedef struct packed {
        logic [15:0] tick_period;
        logic [15:0] timeout_ticks;
        logic [15:0] linear_accel;
        logic [15:0] angular_accel;
        logic [15:0] linear_brake;
        logic [15:0] angular_brake;
    } cfg_t;

    typedef struct packed {
        logic accept;
        logic mul_d;
        logic ramp;
        logic mul_p;
        logic mul_h;
        logic add_h;
        logic cinit;
        logic citer;
        logic pmul_x;
        logic pmul_y;
        logic padd_y;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic cordic_last;
        logic out_busy;
    } sts_t;

    // Arctangent of 2^-i as a binary angle in Q2.30 (a quarter turn is 2^30).
    function automatic logic [31:0] atan_lookup(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: hw/rtl/vro_in_if.sv
interface vro_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic signed [15:0] target_linear;
    logic signed [15:0] target_angular;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic [15:0]        pose_heading;

    modport source (output valid, opcode, target_linear, target_angular, pose_x, pose_y,
                    pose_heading, input ready);
    modport sink (input valid, opcode, target_linear, target_angular, pose_x, pose_y,
                  pose_heading, output ready);
endinterface

FILE: hw/rtl/vro_out_if.sv
interface vro_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] speed_linear;
    logic signed [15:0] speed_angular;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        heading;
    logic               command_expired;

    modport source (output valid, speed_linear, speed_angular, pos_x, pos_y, heading,
                    command_expired, input ready);
    modport sink (input valid, speed_linear, speed_angular, pos_x, pos_y, heading,
                  command_expired, output ready);
endinterface

FILE: hw/rtl/vro_ctrl.sv
module vro_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [1:0]    in_opcode,
    output logic          in_ready,
    input  vro_pkg::sts_t sts,
    output vro_pkg::cmd_t cmd
);
    import vro_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MULD  = 4'd1;
    localparam logic [3:0] S_RAMP  = 4'd2;
    localparam logic [3:0] S_MULP  = 4'd3;
    localparam logic [3:0] S_MULH  = 4'd4;
    localparam logic [3:0] S_ADDH  = 4'd5;
    localparam logic [3:0] S_CINIT = 4'd6;
    localparam logic [3:0] S_CITER = 4'd7;
    localparam logic [3:0] S_PMX   = 4'd8;
    localparam logic [3:0] S_PMY   = 4'd9;
    localparam logic [3:0] S_PADY  = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    logic [3:0] state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = (in_opcode == OP_TICK) ? S_MULD : S_DONE;
                end
            end
            S_MULD:
            begin
                cmd.mul_d = 1'b1;
                state_next = S_RAMP;
            end
            S_RAMP:
            begin
                cmd.ramp = 1'b1;
                state_next = S_MULP;
            end
            S_MULP:
            begin
                cmd.mul_p = 1'b1;
                state_next = S_MULH;
            end
            S_MULH:
            begin
                cmd.mul_h = 1'b1;
                state_next = S_ADDH;
            end
            S_ADDH:
            begin
                cmd.add_h = 1'b1;
                state_next = S_CINIT;
            end
            S_CINIT:
            begin
                cmd.cinit = 1'b1;
                state_next = S_CITER;
            end
            S_CITER:
            begin
                cmd.citer = 1'b1;
                if (sts.cordic_last)
                begin
                    state_next = S_PMX;
                end
            end
            S_PMX:
            begin
                cmd.pmul_x = 1'b1;
                state_next = S_PMY;
            end
            S_PMY:
            begin
                cmd.pmul_y = 1'b1;
                state_next = S_PADY;
            end
            S_PADY:
            begin
                cmd.padd_y = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hw/rtl/vro_datapath.sv
module vro_datapath #(
    parameter int TRIG_ITERATIONS = vro_pkg::TrigIterationsDefault
) (
    input  logic               clk,
    input  logic               rst_n,
    input  vro_pkg::cfg_t      cfg,
    input  vro_pkg::cmd_t      cmd,
    output vro_pkg::sts_t      sts,
    input  logic [1:0]         in_opcode,
    input  logic signed [15:0] in_target_linear,
    input  logic signed [15:0] in_target_angular,
    input  logic signed [31:0] in_pose_x,
    input  logic signed [31:0] in_pose_y,
    input  logic [15:0]        in_pose_heading,
    input  logic               out_ready,
    output logic               out_valid,
    output logic signed [15:0] out_speed_linear,
    output logic signed [15:0] out_speed_angular,
    output logic signed [31:0] out_pos_x,
    output logic signed [31:0] out_pos_y,
    output logic [15:0]        out_heading,
    output logic               out_command_expired
);
    import vro_pkg::*;

    localparam int ItW = $clog2(TRIG_ITERATIONS);
    localparam logic [ItW-1:0] ItLast = ItW'(TRIG_ITERATIONS - 1);

    // Odometry state.
    logic signed [15:0] cur_lin_reg, cur_ang_reg, held_lin_reg, held_ang_reg;
    logic signed [31:0] x_reg, y_reg;
    logic [15:0]        head_reg, ticks_reg;

    // Working registers.
    logic [19:0]        dlin_reg, dang_reg;
    logic signed [32:0] lprod_reg, aprod_reg;
    logic signed [63:0] hprod_reg;
    logic signed [33:0] cx_reg, cy_reg, cz_reg;
    logic [1:0]         quad_reg;
    logic [ItW-1:0]     it_reg;
    logic signed [66:0] mx_reg, my_reg;
    logic               out_valid_reg;

    logic               expired;
    logic signed [15:0] tgt_lin, tgt_ang;
    logic [15:0]        acc_lin, acc_ang;
    logic [31:0]        dlin_full, dang_full;
    logic signed [16:0] period_s;
    logic signed [63:0] hsum;
    logic [15:0]        head_rot, rem16;
    logic [1:0]         quad;
    logic signed [33:0] xs, ys, atan_s, cos_v, sin_v;
    logic signed [66:0] mx_sum, my_sum, mx_sh, my_sh;

    // Step toward the target by d, never passing it.
    function automatic logic signed [15:0] ramp_step(input logic signed [15:0] cur,
                                                     input logic signed [15:0] tgt,
                                                     input logic [19:0] d);
        logic signed [21:0] c22, t22, n;
        c22 = 22'(cur);
        t22 = 22'(tgt);
        n = c22;
        if (cur < tgt)
        begin
            n = c22 + $signed({2'b00, d});
            if (n > t22)
            begin
                n = t22;
            end
        end
        else if (cur > tgt)
        begin
            n = c22 - $signed({2'b00, d});
            if (n < t22)
            begin
                n = t22;
            end
        end
        return n[15:0];
    endfunction

    assign expired  = ticks_reg > cfg.timeout_ticks;
    assign tgt_lin  = expired ? 16'sd0 : held_lin_reg;
    assign tgt_ang  = expired ? 16'sd0 : held_ang_reg;
    assign acc_lin  = expired ? cfg.linear_brake : cfg.linear_accel;
    assign acc_ang  = expired ? cfg.angular_brake : cfg.angular_accel;
    assign dlin_full = acc_lin * cfg.tick_period;
    assign dang_full = acc_ang * cfg.tick_period;
    assign period_s = $signed({1'b0, cfg.tick_period});

    // Heading step rounded half up; only the low 16 bits of the step matter.
    assign hsum = hprod_reg + (64'sd1 <<< 43);

    // Quadrant reduction of the heading.
    assign head_rot = head_reg + 16'h2000;
    assign quad     = head_rot[15:14];
    assign rem16    = head_reg - {quad, 14'b0};

    // One CORDIC rotation per cycle.
    assign xs     = cx_reg >>> it_reg;
    assign ys     = cy_reg >>> it_reg;
    assign atan_s = $signed({2'b00, atan_lookup(5'(it_reg))});

    always_comb
    begin
        case (quad_reg)
            2'd0:
            begin
                cos_v = cx_reg;
                sin_v = cy_reg;
            end
            2'd1:
            begin
                cos_v = -cy_reg;
                sin_v = cx_reg;
            end
            2'd2:
            begin
                cos_v = -cx_reg;
                sin_v = -cy_reg;
            end
            default:
            begin
                cos_v = cy_reg;
                sin_v = -cx_reg;
            end
        endcase
    end

    // Position steps rounded half up.
    assign mx_sum = mx_reg + (67'sd1 <<< 41);
    assign my_sum = my_reg + (67'sd1 <<< 41);
    assign mx_sh  = mx_sum >>> 42;
    assign my_sh  = my_sum >>> 42;

    assign sts.cordic_last = (it_reg == ItLast);
    assign sts.out_busy    = out_valid_reg && !out_ready;

    // Control state: counter, targets, speeds and pose.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_lin_reg  <= '0;
            cur_ang_reg  <= '0;
            held_lin_reg <= '0;
            held_ang_reg <= '0;
            x_reg        <= '0;
            y_reg        <= '0;
            head_reg     <= '0;
            ticks_reg    <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                case (in_opcode)
                    OP_COMMAND:
                    begin
                        held_lin_reg <= in_target_linear;
                        held_ang_reg <= in_target_angular;
                        ticks_reg    <= '0;
                    end
                    OP_TICK:
                    begin
                        if (ticks_reg != 16'hFFFF)
                        begin
                            ticks_reg <= ticks_reg + 16'd1;
                        end
                    end
                    OP_SET:
                    begin
                        cur_lin_reg <= in_target_linear;
                        cur_ang_reg <= in_target_angular;
                        x_reg       <= in_pose_x;
                        y_reg       <= in_pose_y;
                        head_reg    <= in_pose_heading;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.ramp)
            begin
                cur_lin_reg <= ramp_step(cur_lin_reg, tgt_lin, dlin_reg);
                cur_ang_reg <= ramp_step(cur_ang_reg, tgt_ang, dang_reg);
            end
            if (cmd.add_h)
            begin
                head_reg <= head_reg + hsum[59:44];
            end
            if (cmd.pmul_y)
            begin
                x_reg <= x_reg + mx_sh[31:0];
            end
            if (cmd.padd_y)
            begin
                y_reg <= y_reg + my_sh[31:0];
            end
        end
    end

    // Arithmetic working registers.
    always_ff @(posedge clk)
    begin
        if (cmd.mul_d)
        begin
            dlin_reg <= dlin_full[31:12];
            dang_reg <= dang_full[31:12];
        end
        if (cmd.mul_p)
        begin
            lprod_reg <= cur_lin_reg * period_s;
            aprod_reg <= cur_ang_reg * period_s;
        end
        if (cmd.mul_h)
        begin
            hprod_reg <= 64'(aprod_reg) * $signed({33'd0, RAD_TO_TURN});
        end
        if (cmd.cinit)
        begin
            cx_reg   <= $signed({2'b00, CORDIC_START});
            cy_reg   <= '0;
            cz_reg   <= $signed({{2{rem16[15]}}, rem16, 16'b0});
            quad_reg <= quad;
            it_reg   <= '0;
        end
        if (cmd.citer)
        begin
            if (cz_reg >= 0)
            begin
                cx_reg <= cx_reg - ys;
                cy_reg <= cy_reg + xs;
                cz_reg <= cz_reg - atan_s;
            end
            else
            begin
                cx_reg <= cx_reg + ys;
                cy_reg <= cy_reg - xs;
                cz_reg <= cz_reg + atan_s;
            end
            it_reg <= it_reg + 1'b1;
        end
        if (cmd.pmul_x)
        begin
            mx_reg <= 67'(lprod_reg) * 67'(cos_v);
        end
        if (cmd.pmul_y)
        begin
            my_reg <= 67'(lprod_reg) * 67'(sin_v);
        end
    end

    // Output word register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_speed_linear    <= cur_lin_reg;
            out_speed_angular   <= cur_ang_reg;
            out_pos_x           <= x_reg;
            out_pos_y           <= y_reg;
            out_heading         <= head_reg;
            out_command_expired <= expired;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: hw/rtl/velocity_ramp_odometry_core.sv
// Channel  Role    Word
// in_ch    sink    opcode, target speeds, pose to set
// out_ch   source  speeds, pose, heading, expiry flag
// apb      slave   six 16-bit registers at 4*i
//
// A command, set-pose or unused opcode skips the arithmetic and goes to the output load.
// A tick takes longer, set by the shared CORDIC rotation unit and the
// multiply steps that run one at a time.
// One word is in work at a time; a finished word waits in the output register.
// Reset clears control, odometry and out valid; loads the register reset values.
module velocity_ramp_odometry_core #(
    parameter int TRIG_ITERATIONS = vro_pkg::TrigIterationsDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    vro_in_if.sink      in_ch,
    vro_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import vro_pkg::*;

    cfg_t cfg_reg;
    cmd_t cmd;
    sts_t sts;

    assign pready = 1'b1;

    // Register file writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tick_period   <= 16'd655;
            cfg_reg.timeout_ticks <= 16'd50;
            cfg_reg.linear_accel  <= 16'd256;
            cfg_reg.angular_accel <= 16'd256;
            cfg_reg.linear_brake  <= 16'd512;
            cfg_reg.angular_brake <= 16'd512;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[4:2])
                REG_TICK_PERIOD:   cfg_reg.tick_period   <= pwdata[15:0];
                REG_TIMEOUT_TICKS: cfg_reg.timeout_ticks <= pwdata[15:0];
                REG_LINEAR_ACCEL:  cfg_reg.linear_accel  <= pwdata[15:0];
                REG_ANGULAR_ACCEL: cfg_reg.angular_accel <= pwdata[15:0];
                REG_LINEAR_BRAKE:  cfg_reg.linear_brake  <= pwdata[15:0];
                REG_ANGULAR_BRAKE: cfg_reg.angular_brake <= pwdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    // Register read back.
    always_comb
    begin
        unique case (paddr[4:2])
            REG_TICK_PERIOD:   prdata = {16'd0, cfg_reg.tick_period};
            REG_TIMEOUT_TICKS: prdata = {16'd0, cfg_reg.timeout_ticks};
            REG_LINEAR_ACCEL:  prdata = {16'd0, cfg_reg.linear_accel};
            REG_ANGULAR_ACCEL: prdata = {16'd0, cfg_reg.angular_accel};
            REG_LINEAR_BRAKE:  prdata = {16'd0, cfg_reg.linear_brake};
            REG_ANGULAR_BRAKE: prdata = {16'd0, cfg_reg.angular_brake};
            default:           prdata = 32'd0;
        endcase
    end

    vro_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_opcode (in_ch.opcode),
        .in_ready  (in_ch.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    vro_datapath #(
        .TRIG_ITERATIONS (TRIG_ITERATIONS)
    ) u_datapath (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg                 (cfg_reg),
        .cmd                 (cmd),
        .sts                 (sts),
        .in_opcode           (in_ch.opcode),
        .in_target_linear    (in_ch.target_linear),
        .in_target_angular   (in_ch.target_angular),
        .in_pose_x           (in_ch.pose_x),
        .in_pose_y           (in_ch.pose_y),
        .in_pose_heading     (in_ch.pose_heading),
        .out_ready           (out_ch.ready),
        .out_valid           (out_ch.valid),
        .out_speed_linear    (out_ch.speed_linear),
        .out_speed_angular   (out_ch.speed_angular),
        .out_pos_x           (out_ch.pos_x),
        .out_pos_y           (out_ch.pos_y),
        .out_heading         (out_ch.heading),
        .out_command_expired (out_ch.command_expired)
    );

endmodule

FILE: dv/tb_velocity_ramp_odometry_core.sv
module tb_velocity_ramp_odometry_core;
    import vro_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [2:0] REG_SPARE = 3'd6;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int PHASES = 5;
    localparam int ITEMS_PER_PHASE = 360;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic signed [15:0] speed_linear;
        logic signed [15:0] speed_angular;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [15:0]        heading;
        logic               command_expired;
    } odo_word_t;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [15:0] target_linear;
        logic signed [15:0] target_angular;
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
        logic [15:0]        pose_heading;
    } drive_word_t;

    typedef struct packed {
        drive_word_t stim;
        logic        typed;
        odo_word_t   want;
    } directed_row_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    vro_in_if  in_ch();
    vro_out_if out_ch();

    velocity_ramp_odometry_core i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the block's registers and motion state.
    cfg_t              shadow_cfg;
    logic signed [15:0] m_lin;
    logic signed [15:0] m_ang;
    logic signed [15:0] m_held_lin;
    logic signed [15:0] m_held_ang;
    logic [31:0]        m_x;
    logic [31:0]        m_y;
    logic [15:0]        m_heading;
    logic [15:0]        m_ticks;

    odo_word_t pending_words[$];
    int        errors = 0;
    int        cycles = 0;
    bit        sink_burst = 1'b0;
    bit        source_burst = 1'b0;

    longint arctan_q30[24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81
    };

    always #10 clk = ~clk;

    // Free-running cycle count guards against a hung handshake.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Move one speed toward its target by one acceleration step, clamping at the target.
    function automatic logic signed [15:0] slew(input logic signed [15:0] cur,
                                                input logic signed [15:0] tgt,
                                                input logic [15:0] rate);
        longint step;
        longint next;
        step = (longint'(rate) * longint'(shadow_cfg.tick_period)) >> 12;
        next = cur;
        if (cur < tgt)
        begin
            next = cur + step;
            if (next > tgt)
                next = tgt;
        end
        else if (cur > tgt)
        begin
            next = cur - step;
            if (next < tgt)
                next = tgt;
        end
        return next[15:0];
    endfunction

    // Cosine and sine of a binary angle in Q2.30, by quadrant folding and CORDIC rotation.
    task automatic sincos(input logic [15:0] angle, output longint cosv, output longint sinv);
        logic [31:0] a;
        logic [31:0] quad;
        logic [31:0] resid;
        longint      z;
        longint      xv;
        longint      yv;
        longint      tmp;
        a = {angle, 16'd0};
        quad = ((a + 32'h2000_0000) >> 30) & 32'd3;
        resid = a - (quad << 30);
        z = longint'(signed'(resid));
        xv = longint'(CORDIC_START);
        yv = 0;
        for (int i = 0; i < TrigIterationsDefault; i++)
        begin
            if (z >= 0)
            begin
                tmp = xv - (yv >>> i);
                yv = yv + (xv >>> i);
                z = z - arctan_q30[i];
            end
            else
            begin
                tmp = xv + (yv >>> i);
                yv = yv - (xv >>> i);
                z = z + arctan_q30[i];
            end
            xv = tmp;
        end
        case (quad[1:0])
            2'd0:    begin cosv = xv;  sinv = yv;  end
            2'd1:    begin cosv = -yv; sinv = xv;  end
            2'd2:    begin cosv = -xv; sinv = -yv; end
            default: begin cosv = yv;  sinv = -xv; end
        endcase
    endtask

    // Advance the shadow state by one accepted word and return the word the block should send.
    task automatic advance_odometry(input drive_word_t w, output odo_word_t res);
        logic   expired;
        longint prod;
        longint dh;
        longint dx;
        longint dy;
        longint cosv;
        longint sinv;
        case (w.opcode)
            OP_COMMAND:
            begin
                m_held_lin = w.target_linear;
                m_held_ang = w.target_angular;
                m_ticks = '0;
            end
            OP_TICK:
            begin
                if (m_ticks != 16'hFFFF)
                    m_ticks = m_ticks + 16'd1;
                expired = m_ticks > shadow_cfg.timeout_ticks;
                m_lin = slew(m_lin, expired ? 16'sd0 : m_held_lin,
                             expired ? shadow_cfg.linear_brake : shadow_cfg.linear_accel);
                m_ang = slew(m_ang, expired ? 16'sd0 : m_held_ang,
                             expired ? shadow_cfg.angular_brake : shadow_cfg.angular_accel);
                prod = longint'(m_ang) * longint'(shadow_cfg.tick_period);
                dh = (prod * longint'(RAD_TO_TURN) + (longint'(1) << 43)) >>> 44;
                m_heading = m_heading + dh[15:0];
                sincos(m_heading, cosv, sinv);
                prod = longint'(m_lin) * longint'(shadow_cfg.tick_period);
                dx = (prod * cosv + (longint'(1) << 41)) >>> 42;
                dy = (prod * sinv + (longint'(1) << 41)) >>> 42;
                m_x = m_x + dx[31:0];
                m_y = m_y + dy[31:0];
            end
            OP_SET:
            begin
                m_lin = w.target_linear;
                m_ang = w.target_angular;
                m_x = w.pose_x;
                m_y = w.pose_y;
                m_heading = w.pose_heading;
            end
            default:
            begin
            end
        endcase
        res.speed_linear = m_lin;
        res.speed_angular = m_ang;
        res.pos_x = m_x;
        res.pos_y = m_y;
        res.heading = m_heading;
        res.command_expired = m_ticks > shadow_cfg.timeout_ticks;
    endtask

    // APB write: setup cycle, then access cycle; the shadow follows the write.
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= {16'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_TICK_PERIOD:   shadow_cfg.tick_period = value;
            REG_TIMEOUT_TICKS: shadow_cfg.timeout_ticks = value;
            REG_LINEAR_ACCEL:  shadow_cfg.linear_accel = value;
            REG_ANGULAR_ACCEL: shadow_cfg.angular_accel = value;
            REG_LINEAR_BRAKE:  shadow_cfg.linear_brake = value;
            REG_ANGULAR_BRAKE: shadow_cfg.angular_brake = value;
            default:           ;
        endcase
    endtask

    function automatic int draw_gap(input bit burst);
        if (burst)
            return 0;
        return $urandom_range(0, 13);
    endfunction

    // Offer one word, hold it until accepted, then queue what it should produce.
    task automatic send_word(input drive_word_t w, input bit typed, input odo_word_t want);
        int        gap;
        odo_word_t predicted;
        gap = draw_gap(source_burst);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.opcode <= w.opcode;
        in_ch.target_linear <= w.target_linear;
        in_ch.target_angular <= w.target_angular;
        in_ch.pose_x <= w.pose_x;
        in_ch.pose_y <= w.pose_y;
        in_ch.pose_heading <= w.pose_heading;
        do
            @(posedge clk);
        while (!in_ch.ready);
        advance_odometry(w, predicted);
        pending_words.push_back(typed ? want : predicted);
    endtask

    function automatic drive_word_t random_word(input int cmd_pct);
        drive_word_t w;
        int pick;
        pick = $urandom_range(0, 99);
        w.target_linear = 16'($urandom);
        w.target_angular = 16'($urandom);
        w.pose_x = $urandom;
        w.pose_y = $urandom;
        w.pose_heading = 16'($urandom);
        // Modest targets keep the ramps realistic most of the time.
        if ($urandom_range(0, 3) != 0)
        begin
            w.target_linear = $signed(w.target_linear) >>> $urandom_range(0, 12);
            w.target_angular = $signed(w.target_angular) >>> $urandom_range(0, 12);
        end
        if (pick < cmd_pct)
            w.opcode = OP_COMMAND;
        else if (pick < cmd_pct + 6)
            w.opcode = OP_SET;
        else if (pick < cmd_pct + 9)
            w.opcode = OP_UNUSED;
        else
            w.opcode = OP_TICK;
        return w;
    endfunction

    // Result side: random stalls, every accepted word compared with the oldest expectation.
    initial
    begin : result_check
        int        gap;
        odo_word_t got;
        odo_word_t want;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = draw_gap(sink_burst);
            if (gap > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_ch.valid);
            got.speed_linear = out_ch.speed_linear;
            got.speed_angular = out_ch.speed_angular;
            got.pos_x = out_ch.pos_x;
            got.pos_y = out_ch.pos_y;
            got.heading = out_ch.heading;
            got.command_expired = out_ch.command_expired;
            if (pending_words.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word %h", $time, got);
            end
            else
            begin
                want = pending_words.pop_front();
                if (got.speed_linear !== want.speed_linear)
                begin
                    errors++;
                    $display("%0t: speed_linear expected %0d got %0d", $time,
                             want.speed_linear, got.speed_linear);
                end
                if (got.speed_angular !== want.speed_angular)
                begin
                    errors++;
                    $display("%0t: speed_angular expected %0d got %0d", $time,
                             want.speed_angular, got.speed_angular);
                end
                if (got.pos_x !== want.pos_x)
                begin
                    errors++;
                    $display("%0t: pos_x expected %h got %h", $time, want.pos_x, got.pos_x);
                end
                if (got.pos_y !== want.pos_y)
                begin
                    errors++;
                    $display("%0t: pos_y expected %h got %h", $time, want.pos_y, got.pos_y);
                end
                if (got.heading !== want.heading)
                begin
                    errors++;
                    $display("%0t: heading expected %h got %h", $time, want.heading, got.heading);
                end
                if (got.command_expired !== want.command_expired)
                begin
                    errors++;
                    $display("%0t: command_expired expected %b got %b", $time,
                             want.command_expired, got.command_expired);
                end
            end
        end
    end

    // Stall patterns change now and then so that long gap-free stretches also occur.
    always @(posedge clk)
    begin
        if ($urandom_range(0, 63) == 0)
            sink_burst <= ($urandom_range(0, 2) == 0);
        if ($urandom_range(0, 63) == 0)
            source_burst <= ($urandom_range(0, 2) == 0);
    end

    initial
    begin : stimulus
        directed_row_t directed[$];
        odo_word_t     none;
        drive_word_t   w;
        int            cmd_pct;

        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.opcode = OP_COMMAND;
        in_ch.target_linear = '0;
        in_ch.target_angular = '0;
        in_ch.pose_x = '0;
        in_ch.pose_y = '0;
        in_ch.pose_heading = '0;
        none = '0;

        shadow_cfg.tick_period = 16'd655;
        shadow_cfg.timeout_ticks = 16'd50;
        shadow_cfg.linear_accel = 16'd256;
        shadow_cfg.angular_accel = 16'd256;
        shadow_cfg.linear_brake = 16'd512;
        shadow_cfg.angular_brake = 16'd512;
        m_lin = '0;
        m_ang = '0;
        m_held_lin = '0;
        m_held_ang = '0;
        m_x = '0;
        m_y = '0;
        m_heading = '0;
        m_ticks = '0;

        // Directed words; rows with a typed result are the ones obvious by inspection.
        directed = '{
            '{'{OP_COMMAND, 16'sd0, 16'sd0, 32'sd0, 32'sd0, 16'd0}, 1'b1,
              '{16'sd0, 16'sd0, 32'sd0, 32'sd0, 16'd0, 1'b0}},
            '{'{OP_SET, 16'sh7FFF, 16'sh8000, 32'sh7FFF_FFFF, 32'sh8000_0000, 16'hFFFF}, 1'b1,
              '{16'sh7FFF, 16'sh8000, 32'sh7FFF_FFFF, 32'sh8000_0000, 16'hFFFF, 1'b0}},
            '{'{OP_UNUSED, 16'sh1234, 16'sh4321, 32'sd5, 32'sd6, 16'd7}, 1'b1,
              '{16'sh7FFF, 16'sh8000, 32'sh7FFF_FFFF, 32'sh8000_0000, 16'hFFFF, 1'b0}},
            '{'{OP_TICK, 16'sd0, 16'sd0, 32'sd0, 32'sd0, 16'd0}, 1'b0, none},
            '{'{OP_TICK, 16'sd0, 16'sd0, 32'sd0, 32'sd0, 16'd0}, 1'b0, none},
            '{'{OP_SET, 16'sh8000, 16'sh7FFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'd0}, 1'b1,
              '{16'sh8000, 16'sh7FFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'd0, 1'b0}},
            '{'{OP_TICK, 16'sd0, 16'sd0, 32'sd0, 32'sd0, 16'd0}, 1'b0, none},
            '{'{OP_COMMAND, 16'sh7FFF, 16'sh8000, 32'sd0, 32'sd0, 16'd0}, 1'b0, none},
            '{'{OP_TICK, 16'sd0, 16'sd0, 32'sd0, 32'sd0, 16'd0}, 1'b0, none},
            '{'{OP_SET, 16'sd0, 16'sd0, 32'sd0, 32'sd0, 16'h4000}, 1'b0, none},
            '{'{OP_TICK, 16'sd0, 16'sd0, 32'sd0, 32'sd0, 16'd0}, 1'b0, none},
            '{'{OP_SET, 16'sd4096, 16'sd0, 32'sd0, 32'sd0, 16'h8000}, 1'b0, none},
            '{'{OP_TICK, 16'sd0, 16'sd0, 32'sd0, 32'sd0, 16'd0}, 1'b0, none},
            '{'{OP_SET, 16'sd4096, 16'sd0, 32'sd0, 32'sd0, 16'hC000}, 1'b0, none},
            '{'{OP_TICK, 16'sd0, 16'sd0, 32'sd0, 32'sd0, 16'd0}, 1'b0, none},
            '{'{OP_COMMAND, 16'sh8000, 16'sh7FFF, 32'sd0, 32'sd0, 16'd0}, 1'b0, none},
            '{'{OP_TICK, 16'sd0, 16'sd0, 32'sd0, 32'sd0, 16'd0}, 1'b0, none},
            '{'{OP_UNUSED, 16'shFFFF, 16'shFFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 16'hFFFF},
              1'b0, none}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_word(directed[i].stim, directed[i].typed, directed[i].want);

        // Random phases, each under its own register setting.
        for (int p = 0; p < PHASES; p++)
        begin
            if (p > 0)
            begin
                in_ch.valid <= 1'b0;
                while (pending_words.size() != 0)
                    @(posedge clk);
                repeat (DRAIN_CYCLES) @(posedge clk);
                case (p)
                    1:
                    begin
                        write_reg(REG_TICK_PERIOD, 16'hFFFF);
                        write_reg(REG_TIMEOUT_TICKS, 16'hFFFF);
                        write_reg(REG_LINEAR_ACCEL, 16'hFFFF);
                        write_reg(REG_ANGULAR_ACCEL, 16'hFFFF);
                        write_reg(REG_LINEAR_BRAKE, 16'hFFFF);
                        write_reg(REG_ANGULAR_BRAKE, 16'hFFFF);
                    end
                    2:
                    begin
                        write_reg(REG_TICK_PERIOD, 16'd1);
                        write_reg(REG_TIMEOUT_TICKS, 16'd0);
                        write_reg(REG_LINEAR_ACCEL, 16'd0);
                        write_reg(REG_ANGULAR_ACCEL, 16'd0);
                        write_reg(REG_LINEAR_BRAKE, 16'd0);
                        write_reg(REG_ANGULAR_BRAKE, 16'd0);
                        write_reg(REG_SPARE, 16'hA5A5);
                    end
                    3:
                    begin
                        write_reg(REG_TICK_PERIOD, 16'($urandom_range(1, 65535)));
                        write_reg(REG_TIMEOUT_TICKS, 16'($urandom_range(0, 40)));
                        write_reg(REG_LINEAR_ACCEL, 16'($urandom));
                        write_reg(REG_ANGULAR_ACCEL, 16'($urandom));
                        write_reg(REG_LINEAR_BRAKE, 16'($urandom));
                        write_reg(REG_ANGULAR_BRAKE, 16'($urandom));
                    end
                    default:
                    begin
                        write_reg(REG_TICK_PERIOD, 16'd655);
                        write_reg(REG_TIMEOUT_TICKS, 16'd5);
                        write_reg(REG_LINEAR_ACCEL, 16'($urandom_range(0, 4095)));
                        write_reg(REG_ANGULAR_ACCEL, 16'($urandom_range(0, 4095)));
                        write_reg(REG_LINEAR_BRAKE, 16'($urandom_range(0, 8191)));
                        write_reg(REG_ANGULAR_BRAKE, 16'($urandom_range(0, 8191)));
                    end
                endcase
            end
            // Rare commands let the counter run past the timeout.
            cmd_pct = (p == 0) ? 2 : (p == 4) ? 8 : 15;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                w = random_word(cmd_pct);
                send_word(w, 1'b0, none);
            end
        end

        in_ch.valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/vro_pkg.sv
hw/rtl/vro_in_if.sv
hw/rtl/vro_out_if.sv
hw/rtl/vro_ctrl.sv
hw/rtl/vro_datapath.sv
hw/rtl/velocity_ramp_odometry_core.sv
dv/tb_velocity_ramp_odometry_core.sv
